[rtl/core/assert_macros.svh]
// Assertion macros for the line editing echo discipline RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

[rtl/core/led_pkg.sv]
// Shared types and constants for the line editing echo discipline.
package led_pkg;

  localparam int unsigned MaxLine = 64;
  localparam int unsigned LenW    = 7;
  localparam int unsigned IdxW    = $clog2(MaxLine);

  localparam logic [LenW-1:0] LimitReset = 7'd40;
  localparam logic [LenW-1:0] LimitMax   = 7'(MaxLine);

  localparam logic [7:0] KeyEnd     = 8'd4;
  localparam logic [7:0] KeyWord    = 8'd23;
  localparam logic [7:0] KeyErase   = 8'd127;
  localparam logic [7:0] KeyKill    = 8'd21;
  localparam logic [7:0] KeyNewline = 8'd10;
  localparam logic [7:0] KeySpace   = 8'd32;

  typedef enum logic [2:0] {
    OpChar,
    OpEnd,
    OpWord,
    OpErase,
    OpKill,
    OpNewline
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] key;
  } cmd_t;

  typedef struct packed {
    logic [LenW-1:0] erased_count;
    logic            echo_valid;
    logic [7:0]      echo_byte;
    logic            newline;
    logic [1:0]      bell_count;
    logic            finished;
  } res_t;

endpackage

[rtl/core/led_key_if.sv]
// Keyboard byte channel: valid/ready handshake with the raw byte.
interface led_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;

  modport source (output valid, output key_byte, input ready);
  modport sink   (input valid, input key_byte, output ready);
endinterface

[rtl/core/led_res_if.sv]
// Result channel: valid/ready handshake with the rendering fields.
interface led_res_if;
  logic       valid;
  logic       ready;
  logic [6:0] erased_count;
  logic       echo_valid;
  logic [7:0] echo_byte;
  logic       newline;
  logic [1:0] bell_count;
  logic       finished;

  modport source (output valid, output erased_count, output echo_valid, output echo_byte,
                  output newline, output bell_count, output finished, input ready);
  modport sink   (input valid, input erased_count, input echo_valid, input echo_byte,
                  input newline, input bell_count, input finished, output ready);
endinterface

[rtl/core/led_front.sv]
// Front end: takes keyboard bytes and classifies them into editing commands.
module led_front (
  led_key_if.sink        key_chan,
  input  logic           full_i,
  output logic           push_o,
  output led_pkg::cmd_t  cmd_o
);

  led_pkg::op_e op;

  always_comb begin
    unique case (key_chan.key_byte)
      led_pkg::KeyEnd:     op = led_pkg::OpEnd;
      led_pkg::KeyWord:    op = led_pkg::OpWord;
      led_pkg::KeyErase:   op = led_pkg::OpErase;
      led_pkg::KeyKill:    op = led_pkg::OpKill;
      led_pkg::KeyNewline: op = led_pkg::OpNewline;
      default:             op = led_pkg::OpChar;
    endcase
  end

  assign key_chan.ready = !full_i;
  assign push_o         = key_chan.valid && !full_i;
  assign cmd_o.op       = op;
  assign cmd_o.key      = key_chan.key_byte;

endmodule

[rtl/core/led_queue.sv]
// Two-entry command queue between the front end and the editing engine.
module led_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  led_pkg::cmd_t  cmd_i,
  input  logic           pop_i,
  output logic           valid_o,
  output logic           full_o,
  output led_pkg::cmd_t  cmd_o
);

  led_pkg::cmd_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign valid_o = count_q != 2'd0;
  assign full_o  = count_q == 2'd2;
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + 1'b1;
    rd_ptr_d = rd_ptr_q + 1'b1;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_d;
      if (pop_i)  rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= cmd_i;
  end

endmodule

[rtl/core/led_back.sv]
// Editing engine: holds the line, carries out commands and registers each result.
`include "assert_macros.svh"

module led_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  input  led_pkg::cmd_t             cmd_i,
  output logic                      pop_o,
  input  logic                      cfg_we_i,
  input  logic [led_pkg::LenW-1:0]  cfg_wdata_i,
  led_res_if.source                 res_chan
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [led_pkg::LenW-1:0] len_q, len_d;
  logic [led_pkg::LenW-1:0] erased_q, erased_d;
  logic                     phase_q, phase_d;
  logic                     done_q, done_d;
  logic [led_pkg::LenW-1:0] limit_q;
  logic                     out_valid_q;
  led_pkg::res_t            res_q, res_new;
  logic                     load;
  logic                     out_free;
  logic                     mem_we;
  logic [led_pkg::LenW-1:0] rd_len;
  logic [led_pkg::IdxW-1:0] rd_addr;
  logic [7:0]               rdata_q;
  logic [7:0]               line_mem [led_pkg::MaxLine];

  assign out_free = !out_valid_q || res_chan.ready;
  assign rd_len   = len_d - 7'd1;
  assign rd_addr  = rd_len[led_pkg::IdxW-1:0];

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    erased_d = erased_q;
    phase_d  = phase_q;
    done_d   = done_q;
    pop_o    = 1'b0;
    load     = 1'b0;
    mem_we   = 1'b0;
    res_new  = '0;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          if (done_q) begin
            // drop anything after the session has ended
            pop_o = 1'b1;
          end else if (cmd_i.op == led_pkg::OpWord && len_q != '0) begin
            pop_o    = 1'b1;
            erased_d = '0;
            phase_d  = 1'b0;
            state_d  = StScan;
          end else if (out_free) begin
            pop_o = 1'b1;
            load  = 1'b1;
            res_new.bell_count = 2'd1;
            unique case (cmd_i.op)
              led_pkg::OpEnd: begin
                if (len_q == '0) begin
                  res_new.newline    = 1'b1;
                  res_new.finished   = 1'b1;
                  res_new.bell_count = 2'd0;
                  done_d             = 1'b1;
                end
              end
              led_pkg::OpWord: begin
              end
              led_pkg::OpErase: begin
                if (len_q != '0) begin
                  len_d                = len_q - 7'd1;
                  res_new.erased_count = 7'd1;
                end else begin
                  res_new.bell_count = 2'd2;
                end
              end
              led_pkg::OpKill: begin
                res_new.erased_count = len_q;
                len_d                = '0;
              end
              led_pkg::OpNewline: begin
                res_new.newline = 1'b1;
                len_d           = '0;
              end
              default: begin
                if (len_q >= limit_q) begin
                  res_new.newline = 1'b1;
                  len_d           = '0;
                end else begin
                  mem_we             = 1'b1;
                  len_d              = len_q + 7'd1;
                  res_new.echo_valid = 1'b1;
                  res_new.echo_byte  = cmd_i.key;
                end
              end
            endcase
          end
        end
      end
      StScan: begin
        // skip trailing spaces, then remove the word up to the next space
        if (phase_q && rdata_q == led_pkg::KeySpace) begin
          state_d = StEmit;
        end else begin
          len_d    = len_q - 7'd1;
          erased_d = erased_q + 7'd1;
          phase_d  = phase_q || (rdata_q != led_pkg::KeySpace);
          if (len_d == '0) state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          load                 = 1'b1;
          res_new.erased_count = erased_q;
          res_new.bell_count   = 2'd1;
          state_d              = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      erased_q    <= '0;
      phase_q     <= 1'b0;
      done_q      <= 1'b0;
      limit_q     <= led_pkg::LimitReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      erased_q <= erased_d;
      phase_q  <= phase_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        // clamp the limit into the usable range
        if (cfg_wdata_i == '0) begin
          limit_q <= 7'd1;
        end else if (cfg_wdata_i > led_pkg::LimitMax) begin
          limit_q <= led_pkg::LimitMax;
        end else begin
          limit_q <= cfg_wdata_i;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= res_new;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) line_mem[len_q[led_pkg::IdxW-1:0]] <= cmd_i.key;
    rdata_q <= line_mem[rd_addr];
  end

  assign res_chan.valid        = out_valid_q;
  assign res_chan.erased_count = res_q.erased_count;
  assign res_chan.echo_valid   = res_q.echo_valid;
  assign res_chan.echo_byte    = res_q.echo_byte;
  assign res_chan.newline      = res_q.newline;
  assign res_chan.bell_count   = res_q.bell_count;
  assign res_chan.finished     = res_q.finished;

  `ASSERT_CLK(len_in_range_a, len_q <= led_pkg::LimitMax)
  `ASSERT_CLK(erased_in_range_a, erased_q <= led_pkg::LimitMax)
  `ASSERT_NEVER(emit_after_done_a, done_q && load)
  `ASSERT_NEVER(write_while_busy_a, mem_we && state_q != StIdle)

endmodule

[rtl/core/line_edit_echo_discipline.sv]
// Top level of the line editing echo discipline.
// Keyboard bytes arrive on key_chan (valid/ready); each one is classified and
// placed in a two-entry command queue, so key_chan keeps taking bytes while
// the engine works or a result waits. The engine holds the current line in a
// 64-byte memory and gives at most one result per byte on res_chan: erase
// count, optional echo, newline, bell count and the finished flag.
// Ordinary keys, erase, kill and end are handled directly by the engine and
// reach res_chan in the cycle after they leave the queue; word kill reads the
// line back one character per cycle through the memory's registered read port
// before its result is registered.
// cfg_we_i/cfg_wdata_i write the line limit (0 reads as 1, values above 64
// as 64); write it only while the block is idle.
// Reset clears the line, the limit to 40 and the finished state; the line
// memory needs no clearing pass. While res_chan is stalled the result is held,
// the engine waits and the queue fills, after which key_chan.ready drops.
// After the end code finishes the session, further bytes are taken and dropped.
module line_edit_echo_discipline (
  input  logic        clk_i,
  input  logic        rst_ni,
  led_key_if.sink     key_chan,
  led_res_if.source   res_chan,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i
);

  led_pkg::cmd_t front_cmd;
  led_pkg::cmd_t queue_cmd;
  logic          push;
  logic          pop;
  logic          queue_full;
  logic          queue_valid;

  led_front u_front (
    .key_chan (key_chan),
    .full_i   (queue_full),
    .push_o   (push),
    .cmd_o    (front_cmd)
  );

  led_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .full_o  (queue_full),
    .cmd_o   (queue_cmd)
  );

  led_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .pop_o       (pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_chan    (res_chan)
  );

endmodule
